>>> rtl/dpsf_pkg.sv
// ----------------------------------------------------------------------------
// Double shift flags package
// Shared types, flag positions and helper functions for the SHLD/SHRD unit.
// ----------------------------------------------------------------------------
package dpsf_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned HalfWidth  = 16;
    localparam int unsigned CountWidth = 5;
    localparam int unsigned RawCount   = 8;
    localparam int unsigned ParityBits = 8;

    // Flag bit positions in the EFLAGS word.
    localparam int unsigned FlagCf = 0;
    localparam int unsigned FlagPf = 2;
    localparam int unsigned FlagAf = 4;
    localparam int unsigned FlagZf = 6;
    localparam int unsigned FlagSf = 7;
    localparam int unsigned FlagOf = 11;

    // Operand word after preparation, waiting for the funnel shift.
    typedef struct packed {
        logic                    skip;
        logic                    defined;
        logic                    left;
        logic                    wide;
        logic [CountWidth-1:0]   nm1;
        logic [2*DataWidth-1:0]  word;
        logic [DataWidth-1:0]    flags;
    } shift_stage_t;

    // Shifted result with the flags that need the pre-shift view.
    typedef struct packed {
        logic                    skip;
        logic                    defined;
        logic [DataWidth-1:0]    result;
        logic                    cf;
        logic                    sf;
        logic                    of;
        logic [DataWidth-1:0]    flags;
    } flag_stage_t;

    function automatic logic [DataWidth-1:0] rev32(input logic [DataWidth-1:0] v);
        logic [DataWidth-1:0] r;
        for (int i = 0; i < DataWidth; i++)
        begin
            r[i] = v[DataWidth-1-i];
        end
        return r;
    endfunction

    // Bit reversal within the operand size; upper half is zero for 16-bit.
    function automatic logic [DataWidth-1:0] rev_op(input logic [DataWidth-1:0] v,
                                                    input logic wide);
        logic [DataWidth-1:0] r;
        r = rev32(v);
        return wide ? r : {{HalfWidth{1'b0}}, r[DataWidth-1:HalfWidth]};
    endfunction

    // Left shifts are done as right shifts on bit-reversed operands.
    function automatic logic [DataWidth-1:0] prep_op(input logic [DataWidth-1:0] v,
                                                     input logic left,
                                                     input logic wide);
        logic [DataWidth-1:0] m;
        m = wide ? v : {{HalfWidth{1'b0}}, v[HalfWidth-1:0]};
        return left ? rev_op(v, wide) : m;
    endfunction

endpackage

>>> rtl/double_precision_shift_flags.sv
// ----------------------------------------------------------------------------
// Double precision shift with flags
// Executes one SHLD or SHRD per request and updates the arithmetic flags.
// ----------------------------------------------------------------------------
// A request is taken on the req channel when req_valid is high and req_stall
// is low; its result is handed over on the res channel when res_valid is high
// and res_stall is low. Each request yields exactly one result.
// The datapath has four register stages: operand preparation, coarse funnel
// shift, fine funnel shift with carry and overflow, and flag assembly into
// the output register. A new request can be taken every cycle while req_stall
// is low, so throughput is one per cycle.
// When the receiver holds res_stall, each stage keeps moving as long as the
// stage after it is empty or moving, so bubbles are squeezed out; once all
// four stages are full, req_stall rises in the same cycle.
// Reset clears every stage valid bit; the pipeline is empty afterwards and
// req_stall is low.
// A zero count, or a count above 16 with 16-bit operands, writes nothing:
// written is low, shifted_result is zero and flags_out equals flags_in.
// ----------------------------------------------------------------------------
module double_precision_shift_flags
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic                                 shift_left,
    input  logic [dpsf_pkg::DataWidth-1:0]       dest_value,
    input  logic [dpsf_pkg::DataWidth-1:0]       fill_value,
    input  logic [dpsf_pkg::RawCount-1:0]        shift_count,
    input  logic                                 operand_size,
    input  logic [dpsf_pkg::DataWidth-1:0]       flags_in,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [dpsf_pkg::DataWidth-1:0]       shifted_result,
    output logic [dpsf_pkg::DataWidth-1:0]       flags_out,
    output logic                                 written,
    output logic                                 count_defined
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    dpsf_pkg::shift_stage_t s1_reg, s1_next;
    dpsf_pkg::shift_stage_t s2_reg, s2_next;
    dpsf_pkg::flag_stage_t  s3_reg, s3_next;

    logic [dpsf_pkg::DataWidth-1:0] result_reg, result_next;
    logic [dpsf_pkg::DataWidth-1:0] flags_reg, flags_next;
    logic                           written_reg, written_next;
    logic                           defined_reg, defined_next;

    // A stage may load when it is empty or its content moves on.
    assign rdy4 = !v4_reg || !res_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req_stall = !rdy1;

    // Stage 1: decode the count and line up the 64-bit funnel word.
    always_comb
    begin
        logic [dpsf_pkg::CountWidth-1:0] n;
        logic [dpsf_pkg::DataWidth-1:0]  d_op;
        logic [dpsf_pkg::DataWidth-1:0]  s_op;
        n = shift_count[dpsf_pkg::CountWidth-1:0];
        d_op = dpsf_pkg::prep_op(dest_value, shift_left, operand_size);
        s_op = dpsf_pkg::prep_op(fill_value, shift_left, operand_size);
        s1_next.left    = shift_left;
        s1_next.wide    = operand_size;
        s1_next.defined = operand_size || (n <= dpsf_pkg::CountWidth'(dpsf_pkg::HalfWidth));
        s1_next.skip    = (n == '0) || !s1_next.defined;
        s1_next.nm1     = n - dpsf_pkg::CountWidth'(1);
        s1_next.flags   = flags_in;
        if (operand_size)
        begin
            s1_next.word = {s_op, d_op};
        end
        else
        begin
            s1_next.word = {{dpsf_pkg::DataWidth{1'b0}},
                            s_op[dpsf_pkg::HalfWidth-1:0], d_op[dpsf_pkg::HalfWidth-1:0]};
        end
    end

    // Stage 2: coarse shift by multiples of four.
    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.word = s1_reg.word >> {s1_reg.nm1[dpsf_pkg::CountWidth-1:2], 2'b00};
    end

    // Stage 3: fine shift. The word now sits one step before the final count,
    // so bit 0 is the last bit shifted out and the low window is the previous value.
    always_comb
    begin
        logic [2*dpsf_pkg::DataWidth-1:0] y;
        logic [dpsf_pkg::DataWidth-1:0]   r_raw;
        logic [dpsf_pkg::DataWidth-1:0]   p_raw;
        logic [dpsf_pkg::DataWidth-1:0]   r;
        logic [dpsf_pkg::DataWidth-1:0]   p;
        y = s2_reg.word >> s2_reg.nm1[1:0];
        if (s2_reg.wide)
        begin
            r_raw = y[dpsf_pkg::DataWidth:1];
            p_raw = y[dpsf_pkg::DataWidth-1:0];
        end
        else
        begin
            r_raw = {{dpsf_pkg::HalfWidth{1'b0}}, y[dpsf_pkg::HalfWidth:1]};
            p_raw = {{dpsf_pkg::HalfWidth{1'b0}}, y[dpsf_pkg::HalfWidth-1:0]};
        end
        r = s2_reg.left ? dpsf_pkg::rev_op(r_raw, s2_reg.wide) : r_raw;
        p = s2_reg.left ? dpsf_pkg::rev_op(p_raw, s2_reg.wide) : p_raw;
        s3_next.skip    = s2_reg.skip;
        s3_next.defined = s2_reg.defined;
        s3_next.flags   = s2_reg.flags;
        s3_next.result  = r;
        s3_next.cf      = s2_reg.left ? (s2_reg.wide ? p[dpsf_pkg::DataWidth-1]
                                                     : p[dpsf_pkg::HalfWidth-1])
                                      : y[0];
        s3_next.sf      = s2_reg.wide ? r[dpsf_pkg::DataWidth-1] : r[dpsf_pkg::HalfWidth-1];
        s3_next.of      = s2_reg.wide ? (r[dpsf_pkg::DataWidth-1] ^ p[dpsf_pkg::DataWidth-1])
                                      : (r[dpsf_pkg::HalfWidth-1] ^ p[dpsf_pkg::HalfWidth-1]);
    end

    // Stage 4: zero and parity, then merge into the flag word.
    always_comb
    begin
        logic [dpsf_pkg::DataWidth-1:0] f;
        f = s3_reg.flags;
        f[dpsf_pkg::FlagCf] = s3_reg.cf;
        f[dpsf_pkg::FlagSf] = s3_reg.sf;
        f[dpsf_pkg::FlagZf] = (s3_reg.result == '0);
        f[dpsf_pkg::FlagPf] = ~^s3_reg.result[dpsf_pkg::ParityBits-1:0];
        f[dpsf_pkg::FlagAf] = 1'b1;
        f[dpsf_pkg::FlagOf] = s3_reg.of;
        defined_next = s3_reg.defined;
        written_next = !s3_reg.skip;
        result_next  = s3_reg.skip ? '0 : s3_reg.result;
        flags_next   = s3_reg.skip ? s3_reg.flags : f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= req_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && req_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg)
        begin
            result_reg  <= result_next;
            flags_reg   <= flags_next;
            written_reg <= written_next;
            defined_reg <= defined_next;
        end
    end

    assign res_valid      = v4_reg;
    assign shifted_result = result_reg;
    assign flags_out      = flags_reg;
    assign written        = written_reg;
    assign count_defined  = defined_reg;

    // An undefined count never writes.
    a_undef_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !count_defined |-> !written)
        else $error("undefined count produced a write");

    // A written result always sets AF and reports ZF from the result itself.
    a_written_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && written |-> flags_out[dpsf_pkg::FlagAf]
                                 && (flags_out[dpsf_pkg::FlagZf] == (shifted_result == '0)))
        else $error("AF or ZF inconsistent with written result");

    // Nothing written means a zero result.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !written |-> shifted_result == '0)
        else $error("non-zero result without a write");

    // With the output stage empty the pipeline can always take a request.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !req_stall)
        else $error("request stalled while output stage is empty");

endmodule
